[rtl/core/bfrs_pkg.sv]
// ----------------------------------------------------------------------------
// bfrs_pkg: shared types and constants of the best-fit region selector
// Holds the field widths, register map and the required-size function.
// ----------------------------------------------------------------------------
package bfrs_pkg;

    localparam int BASE_W = 52;
    localparam int LEN_W  = 53;
    localparam int TYPE_W = 8;
    localparam int NEED_W = 56;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 4;

    localparam int PAGE_BYTES        = 4096;
    localparam int PAGE_SHIFT        = $clog2(PAGE_BYTES);
    localparam int DIR_ENTRY_BYTES   = 8;
    localparam int ADDR_BITS         = 52;
    localparam int LEVEL_FANOUT      = 512;
    localparam int FANOUT_SHIFT      = $clog2(LEVEL_FANOUT);
    localparam int TABLE_ENTRY_BYTES = 8;
    localparam int CNT_W             = LEN_W - PAGE_SHIFT + 1;

    typedef logic [BASE_W-1:0] base_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [TYPE_W-1:0] rtype_t;
    typedef logic [NEED_W-1:0] need_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam rtype_t USABLE_TYPE = rtype_t'(1);

    // Region base is taken in its low ADDR_BITS bits
    localparam logic [63:0] ADDR_MASK64 = (ADDR_BITS >= 64) ? '1 :
                                          ((64'd1 << ADDR_BITS) - 64'd1);
    localparam base_t ADDR_MASK = ADDR_MASK64[BASE_W-1:0];

    // Register map, indexed by paddr[3]
    typedef enum logic {
        REG_MIN_BASE   = 1'b0,
        REG_SPACE_SIZE = 1'b1
    } reg_idx_t;

    localparam base_t MIN_BASE_RESET   = base_t'(64'd1048576);
    localparam len_t  SPACE_SIZE_RESET = len_t'(64'd4294967296);

    function automatic cnt_t round_fanout(input cnt_t x);
        logic [CNT_W:0] t;
        begin
            t = {1'b0, x} + (CNT_W+1)'(LEVEL_FANOUT - 1);
            return {t[CNT_W-1:FANOUT_SHIFT], {FANOUT_SHIFT{1'b0}}};
        end
    endfunction

    // Bytes for the direct map plus a four-level table with one root entry
    function automatic need_t needed_bytes(input len_t space);
        logic [LEN_W:0] sp_round;
        cnt_t           pages;
        cnt_t           pte;
        cnt_t           pde;
        cnt_t           pdpe;
        begin
            sp_round = {1'b0, space} + (LEN_W+1)'(PAGE_BYTES - 1);
            pages    = sp_round[LEN_W:PAGE_SHIFT];
            pte      = round_fanout(pages);
            pde      = round_fanout(pte >> FANOUT_SHIFT);
            pdpe     = round_fanout(pde >> FANOUT_SHIFT);
            return NEED_W'(pages) * NEED_W'(DIR_ENTRY_BYTES)
                 + (NEED_W'(pte) + NEED_W'(pde) + NEED_W'(pdpe) + NEED_W'(1))
                   * NEED_W'(TABLE_ENTRY_BYTES);
        end
    endfunction

endpackage

[rtl/core/best_fit_region_selector_unit.sv]
// ----------------------------------------------------------------------------
// best_fit_region_selector_unit: smallest usable memory region finder
// Scans memory map regions and reports the best fit for the direct map.
// ----------------------------------------------------------------------------
// Takes one region request per cycle unless a last region is held back by a stalled
// result. A region is registered on acceptance and judged in the next cycle against
// min_base and the required size, which is recomputed into a register in the cycle
// after address_space_size is written. The result of a map is loaded into the output
// register when its last region leaves the input register; the output register
// decouples the two sides, so a stalled result only holds back the next last region.
// A miss reports found = 0 with zero base and length. Registers: min_base at 0x0,
// address_space_size at 0x8, both 64-bit wide accesses.
module best_fit_region_selector_unit
    import bfrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // region requests
    input  logic              in_valid,
    output logic              in_ready,
    input  base_t             region_base,
    input  len_t              region_len,
    input  rtype_t            region_type,
    input  logic              is_last,
    // results
    output logic              out_valid,
    input  logic              out_ready,
    output logic              found,
    output base_t             chosen_base,
    output len_t              chosen_len
);

    base_t    min_base_reg;
    len_t     space_size_reg;
    need_t    need_reg;
    reg_idx_t reg_sel;
    logic     cfg_wr;

    logic     s1_valid_reg;
    base_t    s1_base_reg;
    len_t     s1_len_reg;
    rtype_t   s1_type_reg;
    logic     s1_last_reg;

    logic     have_best_reg;
    logic     have_best_next;
    base_t    best_base_reg;
    base_t    best_base_next;
    len_t     best_len_reg;
    len_t     best_len_next;

    logic     out_valid_reg;
    logic     found_reg;
    base_t    chosen_base_reg;
    len_t     chosen_len_reg;

    logic     qualify;
    logic     take;
    logic     s1_advance;
    logic     out_load;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        case (reg_sel)
            REG_MIN_BASE:   prdata = DATA_W'(min_base_reg);
            REG_SPACE_SIZE: prdata = DATA_W'(space_size_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_base_reg   <= MIN_BASE_RESET;
            space_size_reg <= SPACE_SIZE_RESET;
            need_reg       <= needed_bytes(SPACE_SIZE_RESET);
        end
        else
        begin
            if (cfg_wr && reg_sel == REG_MIN_BASE)
            begin
                min_base_reg <= pwdata[BASE_W-1:0];
            end
            if (cfg_wr && reg_sel == REG_SPACE_SIZE)
            begin
                space_size_reg <= pwdata[LEN_W-1:0];
            end
            need_reg <= needed_bytes(space_size_reg);
        end
    end

    // ---------------- input register ----------------
    // A last region needs a free output register before it can retire
    assign s1_advance = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_base_reg <= region_base & ADDR_MASK;
            s1_len_reg  <= region_len;
            s1_type_reg <= region_type;
            s1_last_reg <= is_last;
        end
    end

    // ---------------- judge and track best ----------------
    assign qualify = (s1_type_reg == USABLE_TYPE)
                  && (NEED_W'(s1_len_reg) >= need_reg)
                  && (s1_base_reg >= min_base_reg);
    assign take    = qualify && (!have_best_reg || s1_len_reg < best_len_reg);
    assign out_load = s1_advance && s1_last_reg;

    always_comb
    begin
        have_best_next = have_best_reg;
        best_base_next = best_base_reg;
        best_len_next  = best_len_reg;
        if (s1_advance)
        begin
            if (s1_last_reg)
            begin
                // drop the choice so the next region starts a new map
                have_best_next = 1'b0;
                best_base_next = '0;
                best_len_next  = '0;
            end
            else if (take)
            begin
                have_best_next = 1'b1;
                best_base_next = s1_base_reg;
                best_len_next  = s1_len_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg <= 1'b0;
            best_base_reg <= '0;
            best_len_reg  <= '0;
        end
        else
        begin
            have_best_reg <= have_best_next;
            best_base_reg <= best_base_next;
            best_len_reg  <= best_len_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (take)
            begin
                found_reg       <= 1'b1;
                chosen_base_reg <= s1_base_reg;
                chosen_len_reg  <= s1_len_reg;
            end
            else
            begin
                found_reg       <= have_best_reg;
                chosen_base_reg <= best_base_reg;
                chosen_len_reg  <= best_len_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign chosen_base = chosen_base_reg;
    assign chosen_len  = chosen_len_reg;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the best-fit region selector
// Feeds memory maps under several size and base settings, predicts each
// chosen region in a scoreboard, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_top
    import bfrs_pkg::*;
();

    localparam logic [63:0] BASE_MAX    = (64'd1 << BASE_W) - 64'd1;
    localparam logic [63:0] LEN_TOP     = 64'd1 << 52;
    localparam logic [63:0] FANOUT_MASK = ~64'd511;
    localparam int          ITEM_GOAL   = 700;

    typedef struct packed {
        logic  found;
        base_t base;
        len_t  len;
    } pick_t;

    class pick_scoreboard;
        base_t min_base;
        len_t  space_size;
        logic  have_pick;
        base_t pick_base;
        len_t  pick_len;
        pick_t expected_picks[$];
        int    fail_count;

        function new();
            min_base   = base_t'(64'd1048576);
            space_size = len_t'(64'd4294967296);
            have_pick  = 1'b0;
            pick_base  = '0;
            pick_len   = '0;
            fail_count = 0;
        endfunction

        // Direct map entries plus three table levels rounded to 512 entries and one root entry
        function logic [63:0] need_bytes();
            logic [63:0] pages;
            logic [63:0] pte;
            logic [63:0] pde;
            logic [63:0] pdpe;
            pages = (64'(space_size) + 64'd4095) >> 12;
            pte   = (pages + 64'd511) & FANOUT_MASK;
            pde   = (((pte + 64'd511) >> 9) + 64'd511) & FANOUT_MASK;
            pdpe  = (((pde + 64'd511) >> 9) + 64'd511) & FANOUT_MASK;
            return pages * 64'(DIR_ENTRY_BYTES) + (pte + pde + pdpe + 64'd1) * 64'd8;
        endfunction

        function void note_region(base_t b, len_t l, rtype_t t, logic last);
            pick_t p;
            if (t == USABLE_TYPE && 64'(l) >= need_bytes() && b >= min_base)
            begin
                // strict compare: an equal length keeps the earlier region
                if (!have_pick || l < pick_len)
                begin
                    have_pick = 1'b1;
                    pick_base = b;
                    pick_len  = l;
                end
            end
            if (last)
            begin
                p.found = have_pick;
                p.base  = have_pick ? pick_base : '0;
                p.len   = have_pick ? pick_len : '0;
                expected_picks.push_back(p);
                have_pick = 1'b0;
                pick_base = '0;
                pick_len  = '0;
            end
        endfunction

        function void check_pick(logic f, base_t b, len_t l);
            pick_t want;
            if (expected_picks.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: found=%0b base=%h len=%h", f, b, l);
                return;
            end
            want = expected_picks.pop_front();
            if (want.found !== f || want.base !== b || want.len !== l)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("mismatch: expected found=%0b base=%h len=%h, got found=%0b base=%h len=%h",
                             want.found, want.base, want.len, f, b, l);
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    base_t             region_base = '0;
    len_t              region_len = '0;
    rtype_t            region_type = '0;
    logic              is_last = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              found;
    base_t             chosen_base;
    len_t              chosen_len;

    pick_scoreboard sb = new();
    int             items_sent = 0;
    int             burst_left = 0;
    logic [63:0]    tie_len = 64'd0;
    int             ready_mode = 0;
    int             ready_left = 0;
    int             ready_cyc = 0;

    best_fit_region_selector_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .region_base (region_base),
        .region_len  (region_len),
        .region_type (region_type),
        .is_last     (is_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .chosen_base (chosen_base),
        .chosen_len  (chosen_len)
    );

    always #4 clk = ~clk;

    // Receiver stalls: switch at random among four out_ready patterns
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(16, 200);
        end
        ready_left--;
        ready_cyc++;
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (ready_cyc % 9) < 5;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_pick(found, chosen_base, chosen_len);
    end

    function automatic logic [63:0] rand_bits();
        return {$urandom, $urandom};
    endfunction

    // Random magnitude, from one bit to 56 bits wide
    function automatic logic [63:0] spread();
        return rand_bits() >> $urandom_range(8, 63);
    endfunction

    task automatic send_region(logic [63:0] b, logic [63:0] l, rtype_t t, logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        region_base <= base_t'(b);
        region_len  <= len_t'(l);
        region_type <= t;
        is_last     <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_region(base_t'(b), len_t'(l), t, last);
        items_sent++;
    endtask

    // Hold requests until every pick has come back and the block has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.expected_picks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 3;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MIN_BASE)
            sb.min_base = value[BASE_W-1:0];
        else
            sb.space_size = value[LEN_W-1:0];
        // let the required size register catch up
        repeat (2) @(posedge clk);
    endtask

    function automatic logic [63:0] pick_min_base();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return BASE_MAX;
            2: return 64'd1048576;
            3: return rand_bits() & BASE_MAX;
            4: return rand_bits() >> 40;
            default: return BASE_MAX - (rand_bits() >> 30);
        endcase
    endfunction

    function automatic logic [63:0] pick_space_size();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0: v = 64'd1;
            1: v = LEN_TOP;
            2: v = 64'd4096 * $urandom_range(1, 4096);
            3: v = rand_bits() >> 11;
            4: v = rand_bits() >> 30;
            5: v = 64'd0;
            6: v = 64'd4097;
            default: v = rand_bits() >> $urandom_range(20, 40);
        endcase
        return (v > LEN_TOP) ? LEN_TOP : v;
    endfunction

    task automatic send_random_map();
        int          n;
        int          sel;
        logic [63:0] need;
        logic [63:0] mb;
        logic [63:0] b;
        logic [63:0] l;
        logic [63:0] d;
        rtype_t      t;
        n    = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 9);
        need = sb.need_bytes();
        mb   = 64'(sb.min_base);
        for (int k = 0; k < n; k++)
        begin
            t = USABLE_TYPE;
            b = ($urandom_range(0, 3) == 0) ? mb : mb + spread();
            if (b > BASE_MAX)
                b = BASE_MAX;
            l = ($urandom_range(0, 3) == 0) ? need + $urandom_range(0, 2) : need + spread();
            if (l > LEN_TOP)
                l = LEN_TOP;
            sel = $urandom_range(0, 11);
            if (sel == 7)
                t = rtype_t'($urandom_range(0, 255));
            else if (sel == 8 && mb != 0)
            begin
                d = spread();
                b = (d >= mb) ? 64'd0 : mb - 64'd1 - d;
            end
            else if (sel == 9)
            begin
                d = spread();
                l = (d >= need) ? 64'd0 : need - 64'd1 - d;
            end
            else if (sel == 10 && tie_len >= need)
                l = tie_len;
            else if (sel == 11)
            begin
                b = rand_bits() & BASE_MAX;
                l = ($urandom_range(0, 7) == 0) ? LEN_TOP : rand_bits() >> $urandom_range(12, 52);
                t = rtype_t'($urandom_range(0, 255));
            end
            if (sel < 7)
                tie_len = l;
            send_region(b, l, t, k == n - 1);
        end
    endtask

    initial
    begin
        logic [63:0] need;
        logic [63:0] mb;
        logic [63:0] sz;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: boundaries of base and size, ties, rejected types
        need = sb.need_bytes();
        mb   = 64'(sb.min_base);
        send_region(mb, need, USABLE_TYPE, 1'b0);
        send_region(mb - 64'd1, need + 64'd100, USABLE_TYPE, 1'b0);
        send_region(mb + 64'd4096, need - 64'd1, USABLE_TYPE, 1'b0);
        send_region(BASE_MAX, need, USABLE_TYPE, 1'b0);
        send_region(64'h5_5555_5555_5555 & BASE_MAX, need + 64'd1, 8'd0, 1'b0);
        send_region(BASE_MAX, LEN_TOP, 8'hFF, 1'b1);
        send_region(mb, need, 8'd2, 1'b1);
        send_region(BASE_MAX, LEN_TOP, USABLE_TYPE, 1'b1);
        send_region(64'd0, 64'd0, USABLE_TYPE, 1'b1);
        send_region(mb, need + 64'd10, USABLE_TYPE, 1'b0);
        send_region(mb + 64'd8192, need + 64'd5, USABLE_TYPE, 1'b0);
        send_region(mb + 64'd1, need + 64'd20, USABLE_TYPE, 1'b1);
        settle();

        // zero size: only the root entry is needed
        write_reg(REG_MIN_BASE, 64'd0);
        write_reg(REG_SPACE_SIZE, 64'd0);
        need = sb.need_bytes();
        send_region(64'd0, need, USABLE_TYPE, 1'b1);
        send_region(64'd0, need - 64'd1, USABLE_TYPE, 1'b1);
        send_region(64'd42, need + 64'd1, USABLE_TYPE, 1'b0);
        send_region(64'd7, need, USABLE_TYPE, 1'b1);
        settle();

        write_reg(REG_MIN_BASE, BASE_MAX);
        write_reg(REG_SPACE_SIZE, LEN_TOP);
        send_region(BASE_MAX - 64'd1, LEN_TOP, USABLE_TYPE, 1'b0);
        send_region(BASE_MAX, LEN_TOP, USABLE_TYPE, 1'b1);
        settle();

        write_reg(REG_SPACE_SIZE, 64'd1);
        need = sb.need_bytes();
        send_region(BASE_MAX, need, USABLE_TYPE, 1'b1);
        settle();

        while (items_sent < ITEM_GOAL)
        begin
            // upper data bits beyond the register width must be dropped
            if ($urandom_range(0, 1) == 1)
            begin
                mb = pick_min_base();
                write_reg(REG_MIN_BASE, {($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'd0,
                                         mb[51:0]});
            end
            if ($urandom_range(0, 1) == 1)
            begin
                sz = pick_space_size();
                write_reg(REG_SPACE_SIZE, {($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'd0,
                                           sz[52:0]});
            end
            repeat ($urandom_range(4, 20)) send_random_map();
            settle();
        end

        repeat (8) @(posedge clk);
        if (sb.fail_count == 0 && sb.expected_picks.size() == 0)
            $display("best_fit_region_selector_unit verification clean");
        else
            $display("best_fit_region_selector_unit verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("best_fit_region_selector_unit verification failed");
        $finish;
    end

endmodule
